FILE: hdl/sfd_pkg.sv
`timescale 1ns / 1ps

package sfd_pkg;

    // Default depth of the sync pattern search.
    localparam int MAX_SYNC_BYTES_DEF = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SYNC_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_SYNC_PATTERN  = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD   = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    // Configuration reset values.
    localparam logic [2:0]  SYNC_LENGTH_RST   = 3'd2;
    localparam logic [31:0] SYNC_PATTERN_RST  = 32'h0000_0000;
    localparam logic [11:0] MAX_PAYLOAD_RST   = 12'd4095;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

    // Input opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    // Header byte fields.
    localparam logic [7:0] HDR_ENDPOINT_MASK = 8'hF0;
    localparam logic [7:0] HDR_LENGTH_MASK   = 8'h0F;

endpackage

FILE: hdl/serial_frame_deframer.sv
`timescale 1ns / 1ps

// Serial frame deframer. Each input transaction is either a received byte
// (opcode 0) or one elapsed timer tick (opcode 1). A frame is a sync pattern
// of sync_length bytes (at most MAX_SYNC_BYTES, first byte in the low byte of
// sync_pattern), a header byte holding the endpoint in its high nibble and
// length bits 11..8 in its low nibble, the low length byte, the payload, and
// an 8-bit additive checksum over every earlier byte of the frame. Payload
// bytes are streamed out as kind 0 transactions while they arrive; the frame
// then ends with one transaction marked last, kind 1 (accepted, carrying the
// endpoint and the length) or kind 2 (rejected: sync mismatch after a partial
// match, length above max_payload, bad checksum, or more than timeout_ticks
// ticks without a byte). A first sync byte that does not match is dropped
// without a result, and ticks outside a frame are ignored. The block takes
// one input transaction per clock: all decoding is done in a single pass of
// compare-and-add logic straight into the frame state registers, and any
// result lands in a two-entry output buffer. Input ready falls only while
// both buffer entries hold results that the sink has not yet taken, so with
// the sink always ready the rate is one transaction per cycle and a result
// appears in the cycle after its transaction. Configuration is written
// via cfg_we/cfg_index/cfg_data by the user only while idle (not enforced).

module serial_frame_deframer #(
    parameter int MAX_SYNC_BYTES = sfd_pkg::MAX_SYNC_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,

    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  payload_byte,
    output logic [3:0]  endpoint,
    output logic [11:0] frame_length,
    output logic        last
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SYNC,
        PH_HEADER,
        PH_LENLO,
        PH_DATA,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  endpoint;
        logic [11:0] frame_length;
        logic        last;
    } result_t;

    // Saturation limit for the sync length, four bits wide so that a limit
    // of eight is still representable.
    localparam logic [3:0] MAX_SYNC = 4'(MAX_SYNC_BYTES);

    // Configuration registers.
    logic [2:0]  sync_length_reg;
    logic [31:0] sync_pattern_reg;
    logic [11:0] max_payload_reg;
    logic [31:0] timeout_ticks_reg;

    // Frame state.
    phase_t      phase_reg, phase_next;
    logic [2:0]  sync_matched_reg, sync_matched_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [3:0]  frame_endpoint_reg, frame_endpoint_next;
    logic [3:0]  length_high_reg, length_high_next;
    logic [11:0] total_length_reg, total_length_next;
    logic [11:0] bytes_remaining_reg, bytes_remaining_next;
    logic [31:0] idle_count_reg, idle_count_next;

    // Output buffer: the head entry drives the ports, the skid entry holds a
    // second result while the head is stalled.
    result_t     out_reg, out_next;
    result_t     skid_reg, skid_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;

    // Per-transaction result of the decoder.
    result_t     res;
    logic        res_valid;

    logic        in_fire;
    logic        out_fire;
    logic [2:0]  eff_sync_len;
    logic [3:0][7:0] pattern_bytes;
    logic [7:0]  expected_byte;
    logic [11:0] frame_size;
    logic [31:0] idle_count_inc;
    logic        do_clear;
    logic        as_header;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // A sync length above the limit is treated as the limit.
    assign eff_sync_len = ({1'b0, sync_length_reg} > MAX_SYNC) ? MAX_SYNC[2:0]
                                                                : sync_length_reg;

    // Pattern bytes past the 32-bit register compare against zero.
    assign pattern_bytes = sync_pattern_reg;
    assign expected_byte = sync_matched_reg[2] ? 8'h00 : pattern_bytes[sync_matched_reg[1:0]];

    assign frame_size = {length_high_reg, rx_byte};

    assign idle_count_inc = (idle_count_reg == '1) ? idle_count_reg : idle_count_reg + 32'd1;

    always_comb
    begin
        phase_next           = phase_reg;
        sync_matched_next    = sync_matched_reg;
        running_sum_next     = running_sum_reg;
        frame_endpoint_next  = frame_endpoint_reg;
        length_high_next     = length_high_reg;
        total_length_next    = total_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        idle_count_next      = idle_count_reg;
        res                  = '0;
        res_valid            = 1'b0;
        do_clear             = 1'b0;
        as_header            = 1'b0;

        if (opcode == sfd_pkg::OP_BYTE) begin
            idle_count_next = '0;
            case (phase_reg)
                PH_IDLE, PH_SYNC:
                begin
                    if (sync_matched_reg < eff_sync_len) begin
                        if (rx_byte == expected_byte) begin
                            running_sum_next  = running_sum_reg + rx_byte;
                            sync_matched_next = sync_matched_reg + 3'd1;
                            phase_next = (sync_matched_next >= eff_sync_len) ? PH_HEADER
                                                                             : PH_SYNC;
                        end else begin
                            // A mismatch after a partial match is a reject;
                            // a stray byte while idle is simply dropped.
                            do_clear = 1'b1;
                            if (phase_reg == PH_SYNC) begin
                                res_valid = 1'b1;
                                res.kind  = sfd_pkg::KIND_REJECTED;
                                res.last  = 1'b1;
                            end
                        end
                    end else begin
                        as_header = 1'b1;
                    end
                end
                PH_LENLO:
                begin
                    if (frame_size > max_payload_reg) begin
                        do_clear  = 1'b1;
                        res_valid = 1'b1;
                        res.kind  = sfd_pkg::KIND_REJECTED;
                        res.last  = 1'b1;
                    end else begin
                        total_length_next    = frame_size;
                        bytes_remaining_next = frame_size;
                        phase_next           = (frame_size == '0) ? PH_CHECK : PH_DATA;
                        running_sum_next     = running_sum_reg + rx_byte;
                    end
                end
                PH_DATA:
                begin
                    running_sum_next = running_sum_reg + rx_byte;
                    if (bytes_remaining_reg <= 12'd1) begin
                        bytes_remaining_next = '0;
                        phase_next           = PH_CHECK;
                    end else begin
                        bytes_remaining_next = bytes_remaining_reg - 12'd1;
                    end
                    res_valid        = 1'b1;
                    res.kind         = sfd_pkg::KIND_PAYLOAD;
                    res.payload_byte = rx_byte;
                end
                PH_CHECK:
                begin
                    do_clear  = 1'b1;
                    res_valid = 1'b1;
                    res.last  = 1'b1;
                    if (running_sum_reg == rx_byte) begin
                        res.kind         = sfd_pkg::KIND_ACCEPTED;
                        res.endpoint     = frame_endpoint_reg;
                        res.frame_length = total_length_reg;
                    end else begin
                        res.kind = sfd_pkg::KIND_REJECTED;
                    end
                end
                default:
                begin
                    as_header = 1'b1;
                end
            endcase

            // The header is taken either in its own phase or as soon as the
            // sync pattern is complete.
            if (as_header) begin
                frame_endpoint_next = 4'((rx_byte & sfd_pkg::HDR_ENDPOINT_MASK) >> 4);
                length_high_next    = 4'(rx_byte & sfd_pkg::HDR_LENGTH_MASK);
                running_sum_next    = running_sum_reg + rx_byte;
                phase_next          = PH_LENLO;
            end
        end else if (phase_reg != PH_IDLE) begin
            idle_count_next = idle_count_inc;
            if (idle_count_inc > timeout_ticks_reg) begin
                do_clear  = 1'b1;
                res_valid = 1'b1;
                res.kind  = sfd_pkg::KIND_REJECTED;
                res.last  = 1'b1;
            end
        end

        if (do_clear) begin
            phase_next           = PH_IDLE;
            sync_matched_next    = '0;
            running_sum_next     = '0;
            frame_endpoint_next  = '0;
            length_high_next     = '0;
            total_length_next    = '0;
            bytes_remaining_next = '0;
            idle_count_next      = '0;
        end
    end

    // Two-entry output buffer. A push never meets a full skid entry because
    // input ready is low while the skid entry is occupied.
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end

        if (in_fire && res_valid) begin
            if (!out_valid_reg || (out_fire && !skid_valid_reg)) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_length_reg   <= sfd_pkg::SYNC_LENGTH_RST;
            sync_pattern_reg  <= sfd_pkg::SYNC_PATTERN_RST;
            max_payload_reg   <= sfd_pkg::MAX_PAYLOAD_RST;
            timeout_ticks_reg <= sfd_pkg::TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sfd_pkg::CFG_SYNC_LENGTH:   sync_length_reg   <= cfg_data[2:0];
                sfd_pkg::CFG_SYNC_PATTERN:  sync_pattern_reg  <= cfg_data;
                sfd_pkg::CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[11:0];
                sfd_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:                    sync_length_reg   <= sync_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg           <= PH_IDLE;
            sync_matched_reg    <= '0;
            running_sum_reg     <= '0;
            frame_endpoint_reg  <= '0;
            length_high_reg     <= '0;
            total_length_reg    <= '0;
            bytes_remaining_reg <= '0;
            idle_count_reg      <= '0;
        end else if (in_fire) begin
            phase_reg           <= phase_next;
            sync_matched_reg    <= sync_matched_next;
            running_sum_reg     <= running_sum_next;
            frame_endpoint_reg  <= frame_endpoint_next;
            length_high_reg     <= length_high_next;
            total_length_reg    <= total_length_next;
            bytes_remaining_reg <= bytes_remaining_next;
            idle_count_reg      <= idle_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_reg.kind;
    assign payload_byte = out_reg.payload_byte;
    assign endpoint     = out_reg.endpoint;
    assign frame_length = out_reg.frame_length;
    assign last         = out_reg.last;

    // The skid entry only fills behind a stalled head entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while head entry empty");

    // Payload phase always has at least one byte still to come.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_remaining_reg != '0))
        else $error("payload phase with no bytes remaining");

    // A final status result leaves the frame state fully cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && res.last) |=>
            (phase_reg == PH_IDLE && running_sum_reg == '0 && idle_count_reg == '0))
        else $error("frame state not cleared after final result");

    // A result that leaves the buffer marks last exactly on status kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == (out_reg.kind != sfd_pkg::KIND_PAYLOAD)))
        else $error("last flag does not match result kind");

endmodule
